>>> src/cdfa_pkg.sv
package cdfa_pkg;

  // Fixed field widths
  localparam int CTX_W   = 6;
  localparam int SYM_W   = 4;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 16;
  localparam int RATE_W  = 4;
  localparam int NSYM_W  = 5;

  // Defaults of the top-level parameters
  localparam int NUM_CONTEXTS_DEF = 64;
  localparam int MAX_SYMBOLS_DEF  = 16;

  // Register map: register index = paddr[3:2]
  localparam logic [1:0] REG_NUM_SYMBOLS = 2'd0;
  localparam logic [1:0] REG_MAX_RATE    = 2'd1;
  localparam logic [1:0] REG_INIT_STEP   = 2'd2;
  localparam logic [1:0] REG_INIT_FIRST  = 2'd3;

  // Register reset values
  localparam logic [NSYM_W-1:0] NUM_SYMBOLS_RST = 5'd16;
  localparam logic [RATE_W-1:0] MAX_RATE_RST    = 4'd5;
  localparam logic [VAL_W-1:0]  INIT_STEP_RST   = 16'd2048;
  localparam logic [VAL_W-1:0]  INIT_FIRST_RST  = 16'd2048;

  // Opcodes
  localparam logic OP_ADAPT = 1'b0;
  localparam logic OP_INIT  = 1'b1;

  // Control handed to the entry update unit
  typedef struct packed {
    logic              init;
    logic [IDX_W-1:0]  j;
    logic [SYM_W-1:0]  sym;
    logic [NSYM_W-1:0] n;
    logic [RATE_W-1:0] rate;
    logic [VAL_W-1:0]  step;
    logic [VAL_W-1:0]  first;
  } upd_ctrl_t;

endpackage

>>> src/cdf_adapt_q15.sv
// Adaptive Q15 CDF table. Each context owns MAX_SYMBOLS 16-bit entries in a
// single-port-read table memory plus an adaptation count in a second memory.
// An input word (tuser = opcode, tdata = context and symbol) either adapts the
// context's distribution toward the coded symbol or reloads it with
// init_step*j + init_first; both then stream out the n updated entries, one
// word each, tlast on the final one. After the accept and the count read, one
// entry is produced per cycle while the output does not stall, limited by the
// single read port of the table memory. Results pass through a two-word
// output buffer, so the next word is taken while results wait. Contexts at or
// beyond NUM_CONTEXTS produce nothing. After reset a clearing pass loads the
// flat reset distribution and zero counts; no input word is taken until it
// ends, configuration writes are taken throughout.
module cdf_adapt_q15 import cdfa_pkg::*; #(
  parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
  parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // context_req[5:0], symbol[9:6], zero pad
  input  logic        s_axis_tuser,  // opcode[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // entry_index[3:0], entry_value[19:4], used_rate[23:20]
  output logic        m_axis_tlast,  // last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int DEPTH = NUM_CONTEXTS * MAX_SYMBOLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_CNT  = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  typedef struct packed {
    logic              last;
    logic [RATE_W-1:0] rate;
    logic [VAL_W-1:0]  val;
    logic [IDX_W-1:0]  idx;
  } out_t;

  function automatic logic [4:0] bit_len(input logic [16:0] x);
    logic [4:0] b;
    b = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (x[i]) b = 5'(i + 1);
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  logic [NSYM_W-1:0] num_symbols_q;
  logic [RATE_W-1:0] max_rate_q;
  logic [VAL_W-1:0]  init_step_q;
  logic [VAL_W-1:0]  init_first_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_symbols_q <= NUM_SYMBOLS_RST;
      max_rate_q    <= MAX_RATE_RST;
      init_step_q   <= INIT_STEP_RST;
      init_first_q  <= INIT_FIRST_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_NUM_SYMBOLS: num_symbols_q <= pwdata[NSYM_W-1:0];
        REG_MAX_RATE:    max_rate_q    <= pwdata[RATE_W-1:0];
        REG_INIT_STEP:   init_step_q   <= pwdata[VAL_W-1:0];
        REG_INIT_FIRST:  init_first_q  <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NUM_SYMBOLS: prdata = {27'd0, num_symbols_q};
      REG_MAX_RATE:    prdata = {28'd0, max_rate_q};
      REG_INIT_STEP:   prdata = {16'd0, init_step_q};
      REG_INIT_FIRST:  prdata = {16'd0, init_first_q};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // input decode
  logic [1:0]        state_q, state_d;
  logic              in_acc;
  logic [CTX_W-1:0]  in_ctx;
  logic [SYM_W-1:0]  in_sym;
  logic [11:0]       ctx_ext;
  logic [CW-1:0]     ctx_idx;
  logic              ctx_ok;
  logic [NSYM_W-1:0] nsym;
  logic [SYM_W-1:0]  sym_clamp;

  assign in_ctx  = s_axis_tdata[5:0];
  assign in_sym  = s_axis_tdata[9:6];
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign ctx_ext = {6'd0, in_ctx};
  assign ctx_idx = ctx_ext[CW-1:0];
  assign ctx_ok  = {26'd0, in_ctx} < 32'(NUM_CONTEXTS);

  // symbols in use, clamped to [2, MAX_SYMBOLS]
  always_comb begin
    if (num_symbols_q < 5'd2) begin
      nsym = 5'd2;
    end else if (num_symbols_q > 5'(MAX_SYMBOLS)) begin
      nsym = 5'(MAX_SYMBOLS);
    end else begin
      nsym = num_symbols_q;
    end
  end

  assign sym_clamp = ({1'b0, in_sym} >= nsym) ? 4'(nsym - 5'd1) : in_sym;

  // ---------------------------------------------------------------------
  // operation registers
  logic              op_q;
  logic [CW-1:0]     ctx_q;
  logic [SYM_W-1:0]  sym_q;
  logic [NSYM_W-1:0] n_q;
  logic [AW-1:0]     base_q;
  logic [RATE_W-1:0] rate_q;
  logic [NSYM_W-1:0] iss_j_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      ctx_q  <= ctx_idx;
      sym_q  <= sym_clamp;
      n_q    <= nsym;
      base_q <= AW'(ctx_idx * MAX_SYMBOLS);
    end
  end

  // ---------------------------------------------------------------------
  // clearing pass
  logic [AW-1:0]    clr_addr_q;
  logic [IDX_W-1:0] clr_j_q;
  logic [CW-1:0]    clr_row_q;
  logic             clearing;
  logic             clr_done;
  logic [VAL_W-1:0] clr_val;

  assign clearing = (state_q == ST_CLR);
  assign clr_done = (clr_addr_q == AW'(DEPTH - 1));
  assign clr_val  = INIT_STEP_RST * {12'd0, clr_j_q} + INIT_FIRST_RST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_j_q    <= '0;
      clr_row_q  <= '0;
    end else if (clearing) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_j_q == 4'(MAX_SYMBOLS - 1)) begin
        clr_j_q   <= '0;
        clr_row_q <= clr_row_q + CW'(1);
      end else begin
        clr_j_q <= clr_j_q + 4'd1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // count memory and rate
  logic [VAL_W-1:0]  cnt_rdata;
  logic [16:0]       cap;
  logic [16:0]       cnt_inc;
  logic [16:0]       cnt_sat;
  logic [4:0]        lg;
  logic [RATE_W-1:0] rate_adapt;
  logic              cnt_we;
  logic [CW-1:0]     cnt_waddr;
  logic [VAL_W-1:0]  cnt_wdata;

  assign cap     = 17'd1 << max_rate_q;
  assign cnt_inc = {1'b0, cnt_rdata} + 17'd1;
  assign cnt_sat = (cnt_inc > cap) ? cap : cnt_inc;
  assign lg      = bit_len(17'(n_q >> 2) + cnt_sat);

  // warm-up lowers the shift while the count is below its cap
  assign rate_adapt = ((cnt_sat < cap) && (lg < {1'b0, max_rate_q})) ? lg[RATE_W-1:0]
                                                                    : max_rate_q;

  assign cnt_we    = (clearing && (clr_j_q == '0)) || (state_q == ST_CNT);
  assign cnt_waddr = clearing ? clr_row_q : ctx_q;
  assign cnt_wdata = (clearing || (op_q == OP_INIT)) ? '0 : cnt_sat[VAL_W-1:0];

  cdfa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_CONTEXTS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (in_acc),
    .raddr_i (ctx_idx),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CNT) begin
      rate_q <= (op_q == OP_INIT) ? '0 : rate_adapt;
    end
  end

  // ---------------------------------------------------------------------
  // entry read issue and write-back
  logic [1:0]       fifo_cnt_q;
  logic             pop;
  logic             iss;
  logic             iss_last;
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_j_q;
  logic             rd_last_q;
  logic [AW-1:0]    wr_addr_q;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] cdf_rdata;
  logic [VAL_W-1:0] upd_val;
  upd_ctrl_t        upd_ctrl;

  assign pop      = m_axis_tvalid & m_axis_tready;
  // keep the output buffer from overfilling when the read returns
  assign iss      = (state_q == ST_RUN) &&
                    ((3'(fifo_cnt_q) + 3'(rd_pend_q)) <= (3'd1 + 3'(pop)));
  assign iss_last = (iss_j_q == n_q - 5'd1);
  assign rd_addr  = base_q + AW'(iss_j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      iss_j_q   <= '0;
    end else begin
      rd_pend_q <= iss;
      if (in_acc) begin
        iss_j_q <= '0;
      end else if (iss) begin
        iss_j_q <= iss_j_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss) begin
      rd_j_q    <= iss_j_q[IDX_W-1:0];
      rd_last_q <= iss_last;
      wr_addr_q <= rd_addr;
    end
  end

  assign upd_ctrl = '{
    init:  (op_q == OP_INIT),
    j:     rd_j_q,
    sym:   sym_q,
    n:     n_q,
    rate:  rate_q,
    step:  init_step_q,
    first: init_first_q
  };

  cdfa_upd u_upd (
    .ctrl_i (upd_ctrl),
    .cur_i  (cdf_rdata),
    .val_o  (upd_val)
  );

  cdfa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_cdf_ram (
    .clk_i   (clk_i),
    .we_i    (clearing | rd_pend_q),
    .waddr_i (clearing ? clr_addr_q : wr_addr_q),
    .wdata_i (clearing ? clr_val : upd_val),
    .re_i    (iss),
    .raddr_i (rd_addr),
    .rdata_o (cdf_rdata)
  );

  // ---------------------------------------------------------------------
  // control sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_done) state_d = ST_IDLE;
      ST_IDLE: if (in_acc && ctx_ok) state_d = ST_CNT;
      ST_CNT:  state_d = ST_RUN;
      ST_RUN:  if (iss && iss_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // ---------------------------------------------------------------------
  // two-word output buffer
  out_t fifo_q [2];
  logic wp_q;
  logic rp_q;
  out_t push_word;

  assign push_word = '{last: rd_last_q, rate: rate_q, val: upd_val, idx: rd_j_q};

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      fifo_q[wp_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= 1'b0;
      rp_q       <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      if (rd_pend_q) wp_q <= ~wp_q;
      if (pop)       rp_q <= ~rp_q;
      fifo_cnt_q <= fifo_cnt_q + 2'(rd_pend_q) - 2'(pop);
    end
  end

  assign m_axis_tvalid = (fifo_cnt_q != 2'd0);
  assign m_axis_tdata  = {fifo_q[rp_q].rate, fifo_q[rp_q].val, fifo_q[rp_q].idx};
  assign m_axis_tlast  = fifo_q[rp_q].last;

  // ---------------------------------------------------------------------
  // checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= 2'd2)
    else $error("output buffer overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (fifo_cnt_q < 2'd2) || pop)
    else $error("returning entry finds no room in output buffer");

  a_no_take_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready && !iss)
    else $error("table access during clearing pass");

  a_cnt_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ctx_ok) |=> (state_q == ST_CNT) && !s_axis_tready)
    else $error("accepted word not followed by count stage");

endmodule

>>> src/cdfa_ram.sv
module cdfa_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/cdfa_upd.sv
module cdfa_upd import cdfa_pkg::*; (
  input  upd_ctrl_t        ctrl_i,
  input  logic [VAL_W-1:0] cur_i,
  output logic [VAL_W-1:0] val_o
);

  logic [18:0]      tgt;
  logic [18:0]      diff;
  logic [18:0]      shd;
  logic [VAL_W-1:0] init_val;
  logic [VAL_W-1:0] adapt_val;

  // init: step*j + first, modulo 2^16
  assign init_val = ctrl_i.step * {12'd0, ctrl_i.j} + ctrl_i.first;

  // target sits at the top for entries at or above the symbol, else near zero
  always_comb begin
    if ({1'b0, ctrl_i.j} >= {1'b0, ctrl_i.sym}) begin
      tgt = 19'd32769 + 19'(ctrl_i.j) - 19'(ctrl_i.n);
    end else begin
      tgt = 19'd2 - (19'd1 << ctrl_i.rate) + 19'(ctrl_i.j);
    end
  end

  // floor shift of the signed difference, result wraps to 16 bits
  assign diff      = 19'(cur_i) - tgt;
  assign shd       = 19'($signed(diff) >>> ctrl_i.rate);
  assign adapt_val = cur_i - shd[VAL_W-1:0];

  assign val_o = ctrl_i.init ? init_val : adapt_val;

endmodule

>>> sim/tb_cdf_adapt_q15.sv
`timescale 1ns / 100ps

module tb_cdf_adapt_q15;
  import cdfa_pkg::*;

  localparam int NCTX = NUM_CONTEXTS_DEF;
  localparam int NSYM = MAX_SYMBOLS_DEF;

  // one operation as it travels on the input stream
  typedef struct packed {
    logic             op;
    logic [CTX_W-1:0] ctx;
    logic [SYM_W-1:0] sym;
  } cdf_op_t;

  // one updated table entry as reported on the result stream
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    logic [RATE_W-1:0] rate;
    logic              last;
  } cdf_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // context_req[5:0], symbol[9:6], zero pad
  logic        s_axis_tuser = 1'b0; // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // entry_index[3:0], entry_value[19:4], used_rate[23:20]
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the block's tables and registers
  bit [VAL_W-1:0]  tbl_cdf [NCTX][NSYM];
  bit [15:0]       tbl_count [NCTX];
  bit [NSYM_W-1:0] cfg_nsym = NUM_SYMBOLS_RST;
  bit [RATE_W-1:0] cfg_max_rate = MAX_RATE_RST;
  bit [VAL_W-1:0]  cfg_step = INIT_STEP_RST;
  bit [VAL_W-1:0]  cfg_first = INIT_FIRST_RST;

  cdf_op_t    op_queue [$];
  cdf_entry_t exp_entries [$];
  cdf_op_t    drv_op;
  cdf_entry_t got_entry;
  cdf_entry_t want_entry;

  int  fail_cnt = 0;
  int  src_gap = 0;
  int  snk_gap = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  idle_en = 1'b1;

  cdf_adapt_q15 u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void log_failure(input string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  // Update the shadow row for one accepted operation and queue its entries
  task automatic apply_cdf_op(input cdf_op_t o);
    int n, rate, cap, cnt, lg, s, tgt, cur, diff;
    cdf_entry_t e;
    n = int'(cfg_nsym);
    if (n < 2) n = 2;
    if (n > NSYM) n = NSYM;
    rate = 0;
    if (o.op == OP_INIT) begin
      for (int j = 0; j < n; j++)
        tbl_cdf[o.ctx][IDX_W'(j)] = VAL_W'(int'(cfg_step) * j + int'(cfg_first));
      tbl_count[o.ctx] = '0;
    end else begin
      s = int'(o.sym);
      if (s >= n) s = n - 1;
      rate = int'(cfg_max_rate);
      cap = 1 << rate;
      cnt = int'(tbl_count[o.ctx]) + 1;
      if (cnt > cap) cnt = cap;
      tbl_count[o.ctx] = 16'(cnt);
      // warm-up: smaller shift while the count is below the cap
      if (cnt < cap) begin
        lg = $clog2(n / 4 + cnt + 1);
        if (lg < rate) rate = lg;
      end
      for (int j = 0; j < n; j++) begin
        if (j >= s) tgt = 32769 + j - n;
        else tgt = 2 - (1 << rate) + j;
        cur = int'(tbl_cdf[o.ctx][IDX_W'(j)]);
        diff = cur - tgt;
        cur = cur - (diff >>> rate);
        tbl_cdf[o.ctx][IDX_W'(j)] = cur[15:0];
      end
    end
    for (int j = 0; j < n; j++) begin
      e.idx  = IDX_W'(j);
      e.val  = tbl_cdf[o.ctx][IDX_W'(j)];
      e.rate = RATE_W'(rate);
      e.last = (j == n - 1);
      exp_entries.push_back(e);
    end
  endtask

  // Input side: feed words from the queue, with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_cdf_op(drv_op);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          drv_op = op_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= drv_op.op;
          s_axis_tdata  <= {6'd0, drv_op.sym, drv_op.ctx};
          if (idle_en && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: check each word, drive tready with stalls and long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_entry = {m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tdata[23:20],
                     m_axis_tlast};
        if (exp_entries.size() == 0) begin
          log_failure($sformatf("unexpected result idx=%0d val=%h rate=%0d last=%b",
                                got_entry.idx, got_entry.val, got_entry.rate,
                                got_entry.last));
        end else begin
          want_entry = exp_entries.pop_front();
          if (got_entry.idx !== want_entry.idx || got_entry.val !== want_entry.val ||
              got_entry.rate !== want_entry.rate || got_entry.last !== want_entry.last)
            log_failure($sformatf({"mismatch: exp idx=%0d val=%h rate=%0d last=%b, ",
                                   "got idx=%0d val=%h rate=%0d last=%b"},
              want_entry.idx, want_entry.val, want_entry.rate, want_entry.last,
              got_entry.idx, got_entry.val, got_entry.rate, got_entry.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) snk_gap = $urandom_range(1, 15);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NUM_SYMBOLS: cfg_nsym     = val[NSYM_W-1:0];
      REG_MAX_RATE:    cfg_max_rate = val[RATE_W-1:0];
      REG_INIT_STEP:   cfg_step     = val[VAL_W-1:0];
      REG_INIT_FIRST:  cfg_first    = val[VAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int nsym, input int rate, input int step,
                            input int first);
    write_reg(REG_NUM_SYMBOLS, nsym);
    write_reg(REG_MAX_RATE, rate);
    write_reg(REG_INIT_STEP, step);
    write_reg(REG_INIT_FIRST, first);
  endtask

  // sender pauses here until every queued word is taken and answered
  task automatic wait_drain();
    @(negedge clk_i);
    while (op_queue.size() != 0 || s_axis_tvalid || exp_entries.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_op(input logic op, input int ctx, input int sym);
    cdf_op_t o;
    o.op  = op;
    o.ctx = CTX_W'(ctx);
    o.sym = SYM_W'(sym);
    op_queue.push_back(o);
  endtask

  function automatic cdf_op_t rand_op();
    cdf_op_t o;
    o.op  = ($urandom_range(0, 4) == 0) ? OP_INIT : OP_ADAPT;
    // a few hot contexts so that counts build up and saturate
    o.ctx = CTX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, NCTX - 1)
                                               : $urandom_range(0, 7));
    o.sym = SYM_W'($urandom_range(0, 15));
    return o;
  endfunction

  // Stimulus
  initial begin
    int nsym, rate, step, first;
    for (int c = 0; c < NCTX; c++) begin
      for (int j = 0; j < NSYM; j++)
        tbl_cdf[CTX_W'(c)][IDX_W'(j)] =
          VAL_W'(int'(INIT_STEP_RST) * j + int'(INIT_FIRST_RST));
      tbl_count[CTX_W'(c)] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: both ends of the symbol, both operations, warm-up
    queue_op(OP_ADAPT, 0, 0);
    queue_op(OP_ADAPT, 0, 15);
    queue_op(OP_ADAPT, 63, 7);
    queue_op(OP_INIT, 63, 15);
    for (int k = 0; k < 5; k++) queue_op(OP_ADAPT, 5, 3);
    wait_drain();

    // cap lowered below the count; symbol clamped to n-1
    set_config(4, 1, 1000, 300);
    queue_op(OP_ADAPT, 5, 2);
    queue_op(OP_ADAPT, 9, 15);
    queue_op(OP_INIT, 9, 0);
    wait_drain();

    // n below 2, zero rate, wrapping init values
    set_config(0, 0, 16'hFFFF, 16'hFFFF);
    queue_op(OP_INIT, 1, 9);
    queue_op(OP_ADAPT, 1, 1);
    queue_op(OP_ADAPT, 1, 0);
    wait_drain();

    // n above the maximum, largest rate, init step and first of 32768
    set_config(31, 15, 32768, 32768);
    queue_op(OP_INIT, 2, 0);
    queue_op(OP_ADAPT, 2, 8);
    queue_op(OP_ADAPT, 2, 0);
    queue_op(OP_ADAPT, 2, 15);
    wait_drain();

    // random phases, each with a fresh configuration
    for (int ph = 0; ph < 6; ph++) begin
      nsym  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      rate  = $urandom_range(0, 15);
      step  = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(0, 65535);
      first = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
      if (ph == 5) idle_en = 1'b0;
      set_config(nsym, rate, step, first);
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering
        @(negedge clk_i);
        hold_req = 1'b1;
      end
      for (int k = 0; k < 32; k++) op_queue.push_back(rand_op());
      wait_drain();
    end

    repeat (20) @(posedge clk_i);
    if (exp_entries.size() != 0)
      log_failure($sformatf("%0d expected results never arrived", exp_entries.size()));
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> cdf_adapt_q15.f
src/cdfa_pkg.sv
src/cdfa_ram.sv
src/cdfa_upd.sv
src/cdf_adapt_q15.sv
sim/tb_cdf_adapt_q15.sv
